>>> hw/rtl/bsc_pkg.sv
// Shared constants for the barometric sensor compensation pipeline.
`default_nettype none

package bsc_pkg;

    // Multiply-accumulate trees: limb width of the partial products and tree depth.
    localparam int LIMB_W    = 32;
    localparam int MAC_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LOW  = 2'd0;
    localparam logic [1:0] CFG_MID  = 2'd1;
    localparam logic [1:0] CFG_HIGH = 2'd2;

    // Fraction bits of the temperature and pressure sums.
    localparam int T_FRAC = 48;
    localparam int P_FRAC = 181;

    // Output ranges.
    localparam logic signed [14:0] TEMP_MIN  = -15'sd4000;
    localparam logic signed [14:0] TEMP_MAX  = 15'sd8500;
    localparam logic [23:0]        PRESS_MAX = 24'd15000000;

endpackage

`default_nettype wire

>>> hw/rtl/bsc_mac.sv
// Pipelined signed multiply-accumulate p = a * b + c with a registered adder tree.
`default_nettype none

module bsc_mac #(
    parameter int WA = 32,
    parameter int WB = 32,
    parameter int WC = 32,
    parameter int WP = 68,
    parameter int WS = 1
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 in_valid,
    input  wire logic signed [WA-1:0] a,
    input  wire logic signed [WB-1:0] b,
    input  wire logic signed [WC-1:0] c,
    input  wire logic [WS-1:0]        side,
    output logic                      out_valid,
    output logic signed [WP-1:0]      p,
    output logic [WS-1:0]             side_out
);

    localparam int LW     = bsc_pkg::LIMB_W;
    localparam int NA     = (WA + LW - 1) / LW;
    localparam int NB     = (WB + LW - 1) / LW;
    localparam int NPP    = NA * NB;
    localparam int DEPTH  = bsc_pkg::MAC_DEPTH;
    localparam int LEAVES = 1 << DEPTH;
    localparam int NODES  = 2 * LEAVES - 1;

    logic signed [NA*LW-1:0] a_ext;
    logic signed [NB*LW-1:0] b_ext;
    logic signed [WP-1:0]    leaf_next [LEAVES];
    logic signed [WP-1:0]    node_reg [NODES];
    logic [DEPTH:0]          valid_reg;
    logic [WS-1:0]           side_reg [DEPTH+1];

    assign a_ext = (NA*LW)'(a);
    assign b_ext = (NB*LW)'(b);

    // Lower limbs are unsigned, the top limb carries the sign; the addend takes the
    // leaf after the partial products.
    always_comb
    begin : partial_products
        logic signed [LW:0]     al;
        logic signed [LW:0]     bl;
        logic signed [2*LW+1:0] prod;
        al = '0;
        bl = '0;
        prod = '0;
        for (int j = 0; j < LEAVES; j++)
        begin
            leaf_next[j] = '0;
        end
        for (int i = 0; i < NA; i++)
        begin
            for (int k = 0; k < NB; k++)
            begin
                if (i == NA - 1)
                begin
                    al = (LW+1)'($signed(a_ext[i*LW +: LW]));
                end
                else
                begin
                    al = $signed({1'b0, a_ext[i*LW +: LW]});
                end
                if (k == NB - 1)
                begin
                    bl = (LW+1)'($signed(b_ext[k*LW +: LW]));
                end
                else
                begin
                    bl = $signed({1'b0, b_ext[k*LW +: LW]});
                end
                prod = al * bl;
                leaf_next[i*NB+k] = WP'(prod) <<< (LW * (i + k));
            end
        end
        leaf_next[NPP] = WP'(c);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DEPTH-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < LEAVES - 1; i++)
            begin
                node_reg[i] <= node_reg[2*i+1] + node_reg[2*i+2];
            end
            for (int j = 0; j < LEAVES; j++)
            begin
                node_reg[LEAVES-1+j] <= leaf_next[j];
            end
            side_reg[0] <= side;
            for (int s = 1; s <= DEPTH; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
        end
    end

    assign out_valid = valid_reg[DEPTH];
    assign p         = node_reg[0];
    assign side_out  = side_reg[DEPTH];

endmodule

`default_nettype wire

>>> hw/rtl/baro_sensor_compensation_top.sv
// Top level of the barometric sensor compensation pipeline.
`default_nettype none

// Compensates one raw temperature and pressure pair per clock cycle while the skid
// register is empty and returns the temperature in 0.01 degC and the pressure in 0.01 Pa,
// rounded to nearest and clipped, with a flag in tuser when either value was clipped.
// Registers d, d*T2 and d^2, d^2*T3 and n form the linear temperature; six rounds of
// multiply-accumulate units (partial-product register plus a four-level adder tree)
// evaluate the pressure polynomial by Horner's rule; a tail register takes the
// rounded, clipped result, then the output register. A skid register holds one result
// while the output waits, stalling pipeline and input. The user must write the calibration
// registers only while no transaction is in flight; the block does not enforce it.
module baro_sensor_compensation_top #(
    parameter int RAW_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // raw_temperature [23:0], raw_pressure [47:24]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // temperature_centi [14:0], pressure_centi [38:15]
    output logic             m_tuser    // saturated
);

    localparam int UW = RAW_BITS + 1;
    localparam int TS = 16;

    // Calibration storage and unpacked coefficients.
    logic [63:0]         calib_low_reg;
    logic [63:0]         calib_mid_reg;
    logic [39:0]         calib_high_reg;
    logic [167:0]        calib_bytes;
    logic [15:0]         t1;
    logic [15:0]         t2;
    logic signed [7:0]   t3;
    logic signed [16:0]  p1;
    logic signed [16:0]  p2;
    logic signed [7:0]   p3;
    logic signed [7:0]   p4;
    logic [15:0]         p5;
    logic [15:0]         p6;
    logic signed [7:0]   p7;
    logic signed [7:0]   p8;
    logic signed [15:0]  p9;
    logic signed [7:0]   p10;
    logic signed [7:0]   p11;

    // Front pipeline.
    logic                en;
    logic [23:0]         ut_m;
    logic signed [24:0]  d_next;
    logic signed [UW-1:0] u_next;
    logic [3:0]          front_valid_reg;
    logic signed [24:0]  d_reg;
    logic signed [41:0]  dt2_reg;
    logic signed [49:0]  dd_reg;
    logic signed [41:0]  dt2_s3_reg;
    logic signed [57:0]  ddt3_reg;
    logic signed [59:0]  n_reg;
    logic signed [UW-1:0] u_s1_reg;
    logic signed [UW-1:0] u_s2_reg;
    logic signed [UW-1:0] u_s3_reg;
    logic signed [UW-1:0] u_s4_reg;

    // Multiply-accumulate chain.
    logic                r1_valid;
    logic signed [67:0]  e1;
    logic signed [67:0]  a1;
    logic signed [67:0]  c1;
    logic signed [67:0]  tt;
    logic [59:0]         n1;
    logic [UW-1:0]       u1;
    logic signed [19:0]  rt;
    logic signed [14:0]  t_clip;
    logic                t_sat;
    logic [TS-1:0]       tside1;

    logic                r2_valid;
    logic signed [127:0] e2;
    logic signed [127:0] a2;
    logic signed [68:0]  g1p;
    logic [59:0]         n2;
    logic [UW+TS-1:0]    ut2;

    logic                r3_valid;
    logic signed [187:0] e3;
    logic signed [187:0] bb;
    logic [UW+TS-1:0]    ut3;
    logic [68:0]         g1p3;

    logic                r4_valid;
    logic signed [188:0] g2;
    logic [188+UW+TS-1:0] side4;
    logic signed [187:0] e3_4;
    logic signed [UW-1:0] u4;
    logic [TS-1:0]       tside4;

    logic                r5_valid;
    logic signed [213:0] g3;
    logic [TS-1:0]       tside5;

    logic                r6_valid;
    logic signed [220:0] h;
    logic [TS-1:0]       tside6;

    // Rounding, clipping and output.
    logic signed [39:0]  pr;
    logic [23:0]         p_clip;
    logic                p_sat;
    logic                tail_valid_reg;
    logic [14:0]         tail_t_reg;
    logic [23:0]         tail_p_reg;
    logic                tail_s_reg;
    logic                skid_valid_reg;
    logic [14:0]         skid_t_reg;
    logic [23:0]         skid_p_reg;
    logic                skid_s_reg;
    logic                out_valid_reg;
    logic [14:0]         out_t_reg;
    logic [23:0]         out_p_reg;
    logic                out_s_reg;
    logic                out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            calib_low_reg  <= '0;
            calib_mid_reg  <= '0;
            calib_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bsc_pkg::CFG_LOW:  calib_low_reg  <= cfg_wdata;
                bsc_pkg::CFG_MID:  calib_mid_reg  <= cfg_wdata;
                bsc_pkg::CFG_HIGH: calib_high_reg <= cfg_wdata[39:0];
                default: ;
            endcase
        end
    end

    // Calibration byte k sits at bits 8k+7..8k; pairs are little endian.
    assign calib_bytes = {calib_high_reg, calib_mid_reg, calib_low_reg};
    assign t1  = calib_bytes[15:0];
    assign t2  = calib_bytes[31:16];
    assign t3  = $signed(calib_bytes[39:32]);
    assign p1  = $signed({calib_bytes[55], calib_bytes[55:40]}) - 17'sd16384;
    assign p2  = $signed({calib_bytes[71], calib_bytes[71:56]}) - 17'sd16384;
    assign p3  = $signed(calib_bytes[79:72]);
    assign p4  = $signed(calib_bytes[87:80]);
    assign p5  = calib_bytes[103:88];
    assign p6  = calib_bytes[119:104];
    assign p7  = $signed(calib_bytes[127:120]);
    assign p8  = $signed(calib_bytes[135:128]);
    assign p9  = $signed(calib_bytes[151:136]);
    assign p10 = $signed(calib_bytes[159:152]);
    assign p11 = $signed(calib_bytes[167:160]);

    // The whole pipeline advances unless the skid register is holding a result.
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    assign ut_m   = 24'(s_tdata[RAW_BITS-1:0]);
    assign d_next = $signed({1'b0, ut_m}) - $signed({1'b0, t1, 8'd0});
    assign u_next = $signed({1'b0, s_tdata[24 +: RAW_BITS]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= '0;
        end
        else if (en)
        begin
            front_valid_reg <= {front_valid_reg[2:0], s_tvalid};
        end
    end

    // Linear temperature n = d*T2*2^18 + d^2*T3, scaled by 2^48.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg      <= d_next;
            u_s1_reg   <= u_next;
            dt2_reg    <= d_reg * $signed({1'b0, t2});
            dd_reg     <= d_reg * d_reg;
            u_s2_reg   <= u_s1_reg;
            ddt3_reg   <= dd_reg * t3;
            dt2_s3_reg <= dt2_reg;
            u_s3_reg   <= u_s2_reg;
            n_reg      <= (60'(dt2_s3_reg) <<< 18) + 60'(ddt3_reg);
            u_s4_reg   <= u_s3_reg;
        end
    end

    // First round: innermost Horner terms in n, and the temperature.
    bsc_mac #(.WA(60), .WB(8), .WC(63), .WP(68), .WS(60)) u_mac_e1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(front_valid_reg[3]),
        .a(n_reg), .b(p8), .c($signed({p7, 55'd0})), .side(n_reg),
        .out_valid(r1_valid), .p(e1), .side_out(n1)
    );

    bsc_mac #(.WA(60), .WB(8), .WC(61), .WP(68), .WS(UW)) u_mac_a1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(front_valid_reg[3]),
        .a(n_reg), .b(p4), .c($signed({p3, 53'd0})), .side(u_s4_reg),
        .out_valid(), .p(a1), .side_out(u1)
    );

    bsc_mac #(.WA(60), .WB(8), .WC(64), .WP(68), .WS(1)) u_mac_c1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(front_valid_reg[3]),
        .a(n_reg), .b(p10), .c($signed({p9, 48'd0})), .side(1'b0),
        .out_valid(), .p(c1), .side_out()
    );

    bsc_mac #(.WA(60), .WB(8), .WC(49), .WP(68), .WS(1)) u_mac_t (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(front_valid_reg[3]),
        .a(n_reg), .b(8'sd100), .c($signed({2'b01, 47'd0})), .side(1'b0),
        .out_valid(), .p(tt), .side_out()
    );

    // Temperature: the sum already holds the rounding half, so a shift finishes it.
    assign rt = tt[67:48];
    always_comb
    begin
        t_sat  = 1'b1;
        t_clip = rt[14:0];
        if (rt < bsc_pkg::TEMP_MIN)
        begin
            t_clip = bsc_pkg::TEMP_MIN;
        end
        else if (rt > bsc_pkg::TEMP_MAX)
        begin
            t_clip = bsc_pkg::TEMP_MAX;
        end
        else
        begin
            t_sat = 1'b0;
        end
    end
    assign tside1 = {t_sat, t_clip};

    // Second round.
    bsc_mac #(.WA(68), .WB(60), .WC(122), .WP(128), .WS(60)) u_mac_e2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r1_valid),
        .a(e1), .b($signed(n1)), .c($signed({1'b0, p6, 105'd0})), .side(n1),
        .out_valid(r2_valid), .p(e2), .side_out(n2)
    );

    bsc_mac #(.WA(68), .WB(60), .WC(121), .WP(128), .WS(UW+TS)) u_mac_a2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r1_valid),
        .a(a1), .b($signed(n1)), .c($signed({p2, 104'd0})), .side({u1, tside1}),
        .out_valid(), .p(a2), .side_out(ut2)
    );

    // Constant and u^3 part, scaled down by 2^85.
    bsc_mac #(.WA(UW), .WB(39), .WC(68), .WP(69), .WS(1)) u_mac_g1 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r1_valid),
        .a($signed(u1)), .b($signed({p11, 31'd0})), .c(c1), .side(1'b0),
        .out_valid(), .p(g1p), .side_out()
    );

    // Third round.
    bsc_mac #(.WA(128), .WB(60), .WC(179), .WP(188), .WS(UW+TS)) u_mac_e3 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r2_valid),
        .a(e2), .b($signed(n2)), .c($signed({1'b0, p5, 162'd0})), .side(ut2),
        .out_valid(r3_valid), .p(e3), .side_out(ut3)
    );

    bsc_mac #(.WA(128), .WB(60), .WC(178), .WP(188), .WS(69)) u_mac_b (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r2_valid),
        .a(a2), .b($signed(n2)), .c($signed({p1, 161'd0})), .side(g1p),
        .out_valid(), .p(bb), .side_out(g1p3)
    );

    // Fourth to sixth rounds: Horner steps in u, then the scale by 100 with rounding.
    bsc_mac #(.WA(154), .WB(UW), .WC(188), .WP(189), .WS(188+UW+TS)) u_mac_g2 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r3_valid),
        .a($signed({g1p3, 85'd0})), .b($signed(ut3[UW+TS-1:TS])), .c(bb),
        .side({e3, ut3}),
        .out_valid(r4_valid), .p(g2), .side_out(side4)
    );

    assign e3_4   = $signed(side4[188+UW+TS-1:UW+TS]);
    assign u4     = $signed(side4[UW+TS-1:TS]);
    assign tside4 = side4[TS-1:0];

    bsc_mac #(.WA(189), .WB(UW), .WC(210), .WP(214), .WS(TS)) u_mac_g3 (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r4_valid),
        .a(g2), .b(u4), .c($signed({e3_4, 22'd0})), .side(tside4),
        .out_valid(r5_valid), .p(g3), .side_out(tside5)
    );

    bsc_mac #(.WA(214), .WB(8), .WC(182), .WP(221), .WS(TS)) u_mac_h (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(r5_valid),
        .a(g3), .b(8'sd100), .c($signed({2'b01, 180'd0})), .side(tside5),
        .out_valid(r6_valid), .p(h), .side_out(tside6)
    );

    assign pr = h[220:bsc_pkg::P_FRAC];
    always_comb
    begin
        p_sat  = 1'b1;
        p_clip = pr[23:0];
        if (pr < 40'sd0)
        begin
            p_clip = '0;
        end
        else if (pr > $signed({16'd0, bsc_pkg::PRESS_MAX}))
        begin
            p_clip = bsc_pkg::PRESS_MAX;
        end
        else
        begin
            p_sat = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tail_t_reg <= tside6[14:0];
            tail_p_reg <= p_clip;
            tail_s_reg <= tside6[15] | p_sat;
        end
    end

    // Output register with a skid register behind it.
    assign out_free = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tail_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (en)
            begin
                tail_valid_reg <= r6_valid;
            end
            if (out_free)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= tail_valid_reg;
                end
            end
            else if (en && tail_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_t_reg <= skid_t_reg;
                out_p_reg <= skid_p_reg;
                out_s_reg <= skid_s_reg;
            end
            else
            begin
                out_t_reg <= tail_t_reg;
                out_p_reg <= tail_p_reg;
                out_s_reg <= tail_s_reg;
            end
        end
        else if (en && tail_valid_reg)
        begin
            skid_t_reg <= tail_t_reg;
            skid_p_reg <= tail_p_reg;
            skid_s_reg <= tail_s_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_p_reg, out_t_reg};
    assign m_tuser  = out_s_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bsc_checker.sv
// Port-level assertions for the compensation pipeline, bound to the top level.
`default_nettype none

module bsc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tuser
);

    // A result that is not taken stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output transaction changed while stalled");

    // The input side only stalls while a result is waiting at the output.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with an empty output");

    // Every result lies in its clipped range and the pad bit is zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[14:0]) >= bsc_pkg::TEMP_MIN
            && $signed(m_tdata[14:0]) <= bsc_pkg::TEMP_MAX
            && m_tdata[38:15] <= bsc_pkg::PRESS_MAX && !m_tdata[39])
        else $error("result out of range");

    // A clipped result sits on one of the range limits.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> $signed(m_tdata[14:0]) == bsc_pkg::TEMP_MIN
            || $signed(m_tdata[14:0]) == bsc_pkg::TEMP_MAX
            || m_tdata[38:15] == 24'd0 || m_tdata[38:15] == bsc_pkg::PRESS_MAX)
        else $error("saturation flag without a clipped value");

endmodule

bind baro_sensor_compensation_top bsc_checker u_bsc_checker (.*);

`default_nettype wire
